// ----- src/orcv_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the OR convolution block.
// Depends on nothing; every other file of the block but orcv_ram imports it.
package orcv_pkg;

  localparam int VALUE_W          = 30;
  localparam int INDEX_W          = 6;
  localparam int LOG_W            = 3;
  localparam int DEF_MAX_LOG_SIZE = 6;

  localparam logic [LOG_W-1:0]   LOG_RESET = 3'd6;
  localparam logic [VALUE_W-1:0] PRIME_MOD = 30'd998244353;

  // Barrett factor floor(2^60 / p), worked out at elaboration.
  localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'(PRIME_MOD));

  // Write sources of one lane memory; at most one is set in a cycle.
  typedef struct packed {
    logic wr_load;
    logic wr_bfly;
    logic wr_ext;
    logic inverse;
  } lane_cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [INDEX_W-1:0] index;
    logic               last;
  } out_item_t;

  // Inputs below 2^30 are below twice the prime, so one subtraction reduces them.
  function automatic logic [VALUE_W-1:0] reduce_mod(input logic [VALUE_W-1:0] x);
    reduce_mod = (x >= PRIME_MOD) ? VALUE_W'(x - PRIME_MOD) : x;
  endfunction

endpackage

// ----- src/orcv_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channels of the OR convolution block: operand pairs in, results out.
// Depends on orcv_pkg for the field widths.
interface orcv_operand_if;
  import orcv_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] a_value;
  logic [VALUE_W-1:0] b_value;
  modport source(output valid, a_value, b_value, input ready);
  modport sink(input valid, a_value, b_value, output ready);
endinterface

interface orcv_result_if;
  import orcv_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] result_value;
  logic [INDEX_W-1:0] result_index;
  logic               result_last;
  modport source(output valid, result_value, result_index, result_last, input ready);
  modport sink(input valid, result_value, result_index, result_last, output ready);
endinterface

// ----- src/orcv_ram.sv -----
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
// Depends on nothing.
module orcv_ram #(
  parameter int WIDTH = 30,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr0,
  input  logic [AW-1:0]    raddr1,
  output logic [WIDTH-1:0] rdata0,
  output logic [WIDTH-1:0] rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

// ----- src/orcv_lane.sv -----
`timescale 1ns / 1ps
// One transform lane: a vector memory plus the modular add/subtract butterfly.
// Depends on orcv_pkg and orcv_ram.
module orcv_lane #(
  parameter int MAX_LOG_SIZE = orcv_pkg::DEF_MAX_LOG_SIZE
) (
  input  logic                             clk,
  input  orcv_pkg::lane_cmd_t              cmd,
  input  logic [MAX_LOG_SIZE-1:0]          rd_addr0,
  input  logic [MAX_LOG_SIZE-1:0]          rd_addr1,
  input  logic [MAX_LOG_SIZE-1:0]          wr_addr,
  input  logic [orcv_pkg::VALUE_W-1:0]     load_data,
  input  logic [orcv_pkg::VALUE_W-1:0]     ext_data,
  output logic [orcv_pkg::VALUE_W-1:0]     rd_data0
);
  import orcv_pkg::*;

  logic [VALUE_W-1:0] rd_data1;
  logic [VALUE_W:0]   sum;
  logic [VALUE_W-1:0] bf_res;
  logic [VALUE_W-1:0] wr_data;
  logic               wr_en;

  // Port 0 holds the low element, port 1 the high one; only the high one is rewritten.
  always_comb begin
    if (cmd.inverse) begin
      sum = ({1'b0, rd_data1} + {1'b0, PRIME_MOD}) - {1'b0, rd_data0};
    end else begin
      sum = {1'b0, rd_data0} + {1'b0, rd_data1};
    end
    if (sum >= {1'b0, PRIME_MOD}) begin
      bf_res = VALUE_W'(sum - {1'b0, PRIME_MOD});
    end else begin
      bf_res = VALUE_W'(sum);
    end
  end

  always_comb begin
    wr_en = cmd.wr_load | cmd.wr_bfly | cmd.wr_ext;
    if (cmd.wr_load) begin
      wr_data = load_data;
    end else if (cmd.wr_bfly) begin
      wr_data = bf_res;
    end else begin
      wr_data = ext_data;
    end
  end

  orcv_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(1 << MAX_LOG_SIZE)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr0(rd_addr0),
    .raddr1(rd_addr1),
    .rdata0(rd_data0),
    .rdata1(rd_data1)
  );

endmodule

// ----- src/orcv_modmul.sv -----
`timescale 1ns / 1ps
// Merging stage: pipelined product of the two lanes modulo the prime (Barrett).
// Depends on orcv_pkg.
module orcv_modmul #(
  parameter int MAX_LOG_SIZE = orcv_pkg::DEF_MAX_LOG_SIZE
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [MAX_LOG_SIZE-1:0]      in_addr,
  input  logic [orcv_pkg::VALUE_W-1:0] a,
  input  logic [orcv_pkg::VALUE_W-1:0] b,
  output logic                         out_valid,
  output logic [MAX_LOG_SIZE-1:0]      out_addr,
  output logic [orcv_pkg::VALUE_W-1:0] out_value,
  output logic                         busy
);
  import orcv_pkg::*;

  localparam logic [31:0] P32  = 32'(PRIME_MOD);
  localparam logic [31:0] TWOP = 32'(2 * 64'(PRIME_MOD));

  logic                    v1, v2, v3;
  logic [MAX_LOG_SIZE-1:0] addr1, addr2, addr3;
  logic [59:0]             prod;
  logic [61:0]             q2;
  logic [31:0]             xlo2, xlo3, t3;
  logic [31:0]             r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    addr1 <= in_addr;
    prod  <= 60'(a) * 60'(b);
    addr2 <= addr1;
    q2    <= 62'(prod[59:29]) * 62'(BARRETT_MU);
    xlo2  <= prod[31:0];
    addr3 <= addr2;
    t3    <= 32'(q2[61:31]) * P32;
    xlo3  <= xlo2;
  end

  // The quotient estimate is short by at most two, so the remainder is below 3p < 2^32.
  always_comb begin
    r = xlo3 - t3;
    if (r >= TWOP) begin
      out_value = VALUE_W'(r - TWOP);
    end else if (r >= P32) begin
      out_value = VALUE_W'(r - P32);
    end else begin
      out_value = VALUE_W'(r);
    end
  end

  assign out_valid = v3;
  assign out_addr  = addr3;
  assign busy      = v1 | v2 | v3;

endmodule

// ----- src/or_convolution_mod_prime.sv -----
`timescale 1ns / 1ps
// OR convolution of two length 2^L vectors modulo 998244353.
// Depends on orcv_pkg, orcv_if, orcv_lane and orcv_modmul.
//
// Usage: operand pairs (a_value, b_value) arrive on the operands channel in index
// order. After the 2^L-th pair the block runs the subset-sum transform on both
// vectors in two lanes side by side, multiplies them pointwise in a merging
// multiplier, runs the inverse transform in the first lane and streams the 2^L
// results on the results channel in index order, result_last on the final one.
// L is min(log_size, MAX_LOG_SIZE); cfg_write loads log_size and drops any partly
// loaded vector. operands.ready is high only while pairs are being loaded.
// Timing: loading accepts one pair per cycle while cfg_write is low. Each
// transform does one butterfly per cycle per lane, set by the single write port
// of each lane memory, with a gap cycle before each stage and after the last. The
// pointwise pass ends once the merging multiplier has drained. Results follow the
// inverse transform, one per cycle while the receiver keeps results.ready high.
// Reset returns log_size to 6 and the block to loading at index zero; memories
// are not cleared. When the receiver stalls, up to two results wait in an output
// register and a skid stage; loading of the next vector already goes on.
module or_convolution_mod_prime #(
  parameter int MAX_LOG_SIZE = orcv_pkg::DEF_MAX_LOG_SIZE
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [orcv_pkg::LOG_W-1:0] cfg_data,
  orcv_operand_if.sink               operands,
  orcv_result_if.source              results
);
  import orcv_pkg::*;

  localparam int AW = MAX_LOG_SIZE;
  localparam int LW = $clog2(MAX_LOG_SIZE + 1);
  localparam int CW = (LW > LOG_W) ? LW : LOG_W;

  localparam logic [2:0] ST_LOAD = 3'd0;
  localparam logic [2:0] ST_FWD  = 3'd1;
  localparam logic [2:0] ST_MUL  = 3'd2;
  localparam logic [2:0] ST_INV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [LOG_W-1:0] log_size;
  logic [2:0]       state, state_next;
  logic [AW-1:0]    cnt, cnt_next;
  logic [LW-1:0]    stage, stage_next;
  logic             gap, gap_next;
  logic             done_issue, done_issue_next;
  logic             bf_pend;
  logic [AW-1:0]    bf_waddr;
  logic             mul_pend, out_pend;
  logic [AW-1:0]    rd_addr_q;
  logic             out_pend_last;
  logic             out_valid, skid_valid;
  out_item_t        out_data, skid_data, new_item;

  logic [CW-1:0]      ls_ext;
  logic [LW-1:0]      eff_log;
  logic [AW-1:0]      n_mask, k_last, lmask, half_bit, lo_addr, hi_addr;
  logic [AW-1:0]      rd_addr0;
  logic [AW-1:0]      wr_addr;
  logic               accept, take, bf_issue, mul_issue, out_issue, issue_ok;
  logic [1:0]         occ;
  logic [VALUE_W-1:0] a_red, b_red;
  lane_cmd_t          cmd_a, cmd_b;
  logic [VALUE_W-1:0] a_rd0, b_rd0;
  logic               mul_valid, mul_busy;
  logic [AW-1:0]      mul_addr;
  logic [VALUE_W-1:0] mul_value;
  logic [INDEX_W+AW-1:0] idx_wide;

  always_comb begin
    ls_ext   = CW'(log_size);
    eff_log  = (ls_ext > CW'(MAX_LOG_SIZE)) ? LW'(MAX_LOG_SIZE) : LW'(ls_ext);
    n_mask   = ~({AW{1'b1}} << eff_log);
    k_last   = n_mask >> 1;
    // Butterfly k of a stage: insert a zero at the stage bit to get the low index.
    lmask    = ~({AW{1'b1}} << stage);
    half_bit = AW'(1) << stage;
    lo_addr  = ((cnt & ~lmask) << 1) | (cnt & lmask);
    hi_addr  = lo_addr | half_bit;
  end

  assign accept = operands.valid & operands.ready;
  assign take   = results.valid & results.ready;
  assign a_red  = reduce_mod(operands.a_value);
  assign b_red  = reduce_mod(operands.b_value);
  assign occ      = 2'(out_valid) + 2'(skid_valid) + 2'(out_pend);
  assign issue_ok = (occ - 2'(take)) < 2'd2;

  always_comb begin
    state_next      = state;
    cnt_next        = cnt;
    stage_next      = stage;
    gap_next        = gap;
    done_issue_next = done_issue;
    bf_issue        = 1'b0;
    mul_issue       = 1'b0;
    out_issue       = 1'b0;
    case (state)
      ST_LOAD: begin
        if (cfg_write) begin
          cnt_next = '0;
        end else if (accept) begin
          if (cnt == n_mask) begin
            state_next = ST_FWD;
            cnt_next   = '0;
            stage_next = '0;
            gap_next   = 1'b1;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      ST_FWD, ST_INV: begin
        // The gap cycle lets the last write of a stage land before the next stage reads.
        if (gap) begin
          if (stage == eff_log) begin
            state_next      = (state == ST_FWD) ? ST_MUL : ST_OUT;
            cnt_next        = '0;
            done_issue_next = 1'b0;
          end else begin
            gap_next = 1'b0;
          end
        end else begin
          bf_issue = 1'b1;
          if (cnt == k_last) begin
            cnt_next   = '0;
            stage_next = LW'(stage + 1'b1);
            gap_next   = 1'b1;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      ST_MUL: begin
        if (!done_issue) begin
          mul_issue = 1'b1;
          if (cnt == n_mask) begin
            done_issue_next = 1'b1;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end else if (!mul_pend && !mul_busy) begin
          state_next = ST_INV;
          cnt_next   = '0;
          stage_next = '0;
          gap_next   = 1'b1;
        end
      end
      ST_OUT: begin
        if (issue_ok) begin
          out_issue = 1'b1;
          if (cnt == n_mask) begin
            state_next = ST_LOAD;
            cnt_next   = '0;
          end else begin
            cnt_next = cnt + 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
        cnt_next   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_LOAD;
      cnt        <= '0;
      stage      <= '0;
      gap        <= 1'b0;
      done_issue <= 1'b0;
      log_size   <= LOG_RESET;
      bf_pend    <= 1'b0;
      mul_pend   <= 1'b0;
      out_pend   <= 1'b0;
    end else begin
      state      <= state_next;
      cnt        <= cnt_next;
      stage      <= stage_next;
      gap        <= gap_next;
      done_issue <= done_issue_next;
      bf_pend    <= bf_issue;
      mul_pend   <= mul_issue;
      out_pend   <= out_issue;
      if (cfg_write) begin
        log_size <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    bf_waddr      <= hi_addr;
    rd_addr_q     <= cnt;
    out_pend_last <= (cnt == n_mask);
  end

  assign rd_addr0 = (state == ST_FWD || state == ST_INV) ? lo_addr : cnt;

  always_comb begin
    if (accept) begin
      wr_addr = cnt;
    end else if (bf_pend) begin
      wr_addr = bf_waddr;
    end else begin
      wr_addr = mul_addr;
    end
  end

  always_comb begin
    cmd_a.wr_load = accept;
    cmd_a.wr_bfly = bf_pend;
    cmd_a.wr_ext  = mul_valid;
    cmd_a.inverse = (state == ST_INV);
    cmd_b.wr_load = accept;
    cmd_b.wr_bfly = bf_pend & (state == ST_FWD);
    cmd_b.wr_ext  = 1'b0;
    cmd_b.inverse = 1'b0;
  end

  orcv_lane #(.MAX_LOG_SIZE(MAX_LOG_SIZE)) u_lane_a (
    .clk      (clk),
    .cmd      (cmd_a),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (hi_addr),
    .wr_addr  (wr_addr),
    .load_data(a_red),
    .ext_data (mul_value),
    .rd_data0 (a_rd0)
  );

  orcv_lane #(.MAX_LOG_SIZE(MAX_LOG_SIZE)) u_lane_b (
    .clk      (clk),
    .cmd      (cmd_b),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (hi_addr),
    .wr_addr  (wr_addr),
    .load_data(b_red),
    .ext_data (mul_value),
    .rd_data0 (b_rd0)
  );

  orcv_modmul #(.MAX_LOG_SIZE(MAX_LOG_SIZE)) u_modmul (
    .clk      (clk),
    .rst      (rst),
    .in_valid (mul_pend),
    .in_addr  (rd_addr_q),
    .a        (a_rd0),
    .b        (b_rd0),
    .out_valid(mul_valid),
    .out_addr (mul_addr),
    .out_value(mul_value),
    .busy     (mul_busy)
  );

  always_comb begin
    idx_wide       = {{INDEX_W{1'b0}}, rd_addr_q};
    new_item.value = a_rd0;
    new_item.index = idx_wide[INDEX_W-1:0];
    new_item.last  = out_pend_last;
  end

  // A read issued last cycle lands in the output register if that is free and the
  // skid stage empty, otherwise in the skid stage; the issue check keeps at most two in flight.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= out_pend;
      end else begin
        out_valid <= out_pend;
      end
    end else if (out_pend) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || take) begin
      if (skid_valid) begin
        out_data <= skid_data;
        if (out_pend) begin
          skid_data <= new_item;
        end
      end else if (out_pend) begin
        out_data <= new_item;
      end
    end else if (out_pend) begin
      skid_data <= new_item;
    end
  end

  assign operands.ready       = (state == ST_LOAD) & ~cfg_write;
  assign results.valid        = out_valid;
  assign results.result_value = out_data.value;
  assign results.result_index = out_data.index;
  assign results.result_last  = out_data.last;

  a_skid_needs_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds an item while the output register is empty");

  a_out_capacity: assert property (@(posedge clk) disable iff (rst)
    occ <= 2'd2)
    else $error("more results in flight than the output stages can hold");

  a_bfly_in_transform: assert property (@(posedge clk) disable iff (rst)
    bf_pend |-> (state == ST_FWD || state == ST_INV))
    else $error("butterfly write outside a transform pass");

  a_mul_in_pass: assert property (@(posedge clk) disable iff (rst)
    mul_busy |-> state == ST_MUL)
    else $error("pointwise product still in flight after the pass ended");

  a_load_quiet: assert property (@(posedge clk) disable iff (rst)
    operands.ready |-> (!bf_pend && !mul_pend && !mul_busy))
    else $error("loading while transform or product writes are pending");

endmodule
